// ===== design/cfts_pkg.sv =====
// Shared types, codes and helpers for the case-folded title search core.
package cfts_pkg;

    localparam int TITLE_LEN_DEFAULT = 36;

    // Operation codes carried on the input word
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TITLE  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_NO_MATCH = 2'd0;
    localparam logic [1:0] STATUS_MATCH    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_DELETED  = 2'd3;

    // Classified word passed from the front end through the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  raw_byte;
        logic [7:0]  folded_byte;
        logic [15:0] record_number;
        logic        record_deleted;
        logic        last_byte;
    } cfts_item_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

endpackage

// ===== design/case_folded_title_search_core.sv =====
// Top level of the case-folded title search core.
//
// Searches record titles for a lower-cased pattern, one byte word per cycle
// while the output side is not stalled. A word enters a front register,
// passes a two-word queue and reaches the match engine, which advances
// every bit of the shift-and vector at once; sustained rate is one word per
// clock, and result_valid rises once the title's last byte has passed the
// front register and the queue and set the result register. While a result
// waits, the front register and the queue absorb up to three more words
// before item_ready drops. anchored_mode is written through
// cfg_write_enable/cfg_write_data and applies to every following title byte.
module case_folded_title_search_core
    import cfts_pkg::*;
#(
    parameter int TITLE_LEN = TITLE_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic        cfg_write_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  byte_value,
    input  logic [15:0] record_number,
    input  logic        record_deleted,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [15:0] matched_record
);

    logic       anchored_reg;
    logic       push_valid;
    logic       push_ready;
    cfts_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    cfts_item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            anchored_reg <= 1'b0;
        else if (cfg_write_enable)
            anchored_reg <= cfg_write_data;
    end

    cfts_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .operation      (operation),
        .byte_value     (byte_value),
        .record_number  (record_number),
        .record_deleted (record_deleted),
        .last_byte      (last_byte),
        .push_valid     (push_valid),
        .push_item      (push_item),
        .push_ready     (push_ready)
    );

    cfts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    cfts_engine #(
        .TITLE_LEN (TITLE_LEN)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .anchored_mode  (anchored_reg),
        .pop_valid      (pop_valid),
        .pop_item       (pop_item),
        .pop_ready      (pop_ready),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .matched_record (matched_record)
    );

    // a new result only follows a title word carrying the last-byte mark
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(pop_valid && pop_ready && pop_item.kind == OP_TITLE
                  && pop_item.last_byte))
        else $error("result without a final title word");

    // the engine never takes a word while an untaken result is held
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !pop_ready)
        else $error("engine advanced over a stalled result");

    // unknown operations never enter the queue
    a_known_ops: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_item.kind == OP_CLEAR || push_item.kind == OP_APPEND
                        || push_item.kind == OP_TITLE))
        else $error("unknown operation queued");

endmodule

// ===== design/cfts_front.sv =====
// Front end: registers input words, drops unknown operations, pre-folds the byte.
module cfts_front
    import cfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  byte_value,
    input  logic [15:0] record_number,
    input  logic        record_deleted,
    input  logic        last_byte,
    output logic        push_valid,
    output cfts_item_t  push_item,
    input  logic        push_ready
);

    logic       valid_reg;
    logic       valid_next;
    cfts_item_t item_reg;
    logic       known_op;
    logic       accept;

    assign item_ready = !valid_reg || push_ready;
    assign accept     = item_valid && item_ready;
    assign known_op   = (operation == OP_CLEAR) || (operation == OP_APPEND)
                     || (operation == OP_TITLE);

    always_comb
    begin
        valid_next = valid_reg && !push_ready;
        // drop operation 3 here: it never reaches the back end
        if (accept)
            valid_next = known_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind           <= operation;
            item_reg.raw_byte       <= byte_value;
            item_reg.folded_byte    <= fold_case(byte_value);
            item_reg.record_number  <= record_number;
            item_reg.record_deleted <= record_deleted;
            item_reg.last_byte      <= last_byte;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// ===== design/cfts_queue.sv =====
// Two-word queue that decouples the front end from the match engine.
module cfts_queue
    import cfts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  cfts_item_t push_item,
    output logic       push_ready,
    output logic       pop_valid,
    output cfts_item_t pop_item,
    input  logic       pop_ready
);

    cfts_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== design/cfts_engine.sv =====
// Match engine: pattern storage, shift-and match vector and result register.
module cfts_engine
    import cfts_pkg::*;
#(
    parameter int TITLE_LEN = TITLE_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        anchored_mode,
    input  logic        pop_valid,
    input  cfts_item_t  pop_item,
    output logic        pop_ready,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [15:0] matched_record
);

    localparam int LW = $clog2(TITLE_LEN);
    localparam int PW = $clog2(TITLE_LEN + 1);

    logic [7:0]           pattern_reg [TITLE_LEN];
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        len_next;
    logic [TITLE_LEN-1:0] pmv_reg;
    logic [TITLE_LEN-1:0] pmv_next;
    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        pos_next;
    logic                 term_reg;
    logic                 term_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           status_reg;
    logic [15:0]          record_reg;

    logic                 go;
    logic                 append_ok;
    logic                 in_window;
    logic                 term_now;
    logic                 start_ok;
    logic [7:0]           cmp_byte;
    logic [TITLE_LEN-1:0] step_vec;
    logic                 step_hit;
    logic                 give_result;
    logic [1:0]           result_status;

    assign pop_ready = !out_valid_reg || result_ready;
    assign go        = pop_valid && pop_ready;
    assign append_ok = (pop_item.raw_byte != 8'd0) && (len_reg < LW'(TITLE_LEN - 1));
    assign in_window = (pos_reg < PW'(TITLE_LEN));
    assign term_now  = term_reg || (pop_item.raw_byte == 8'd0);
    assign cmp_byte  = term_now ? pop_item.raw_byte : pop_item.folded_byte;
    assign start_ok  = !anchored_mode || (pos_reg == '0);

    // one shift-and step over every pattern position at once
    always_comb
    begin
        step_vec[0] = start_ok && (pattern_reg[0] == cmp_byte);
        for (int i = 1; i < TITLE_LEN; i++)
            step_vec[i] = (len_reg > LW'(i)) && pmv_reg[i-1]
                       && (pattern_reg[i] == cmp_byte);
    end

    assign step_hit = step_vec[len_reg - 1'b1];

    always_comb
    begin
        len_next    = len_reg;
        pmv_next    = pmv_reg;
        pos_next    = pos_reg;
        term_next   = term_reg;
        hit_next    = hit_reg;
        give_result = 1'b0;
        if (go)
        begin
            unique case (pop_item.kind)
                OP_CLEAR:
                begin
                    len_next  = '0;
                    pmv_next  = '0;
                    pos_next  = '0;
                    term_next = 1'b0;
                    hit_next  = 1'b0;
                end
                OP_APPEND:
                begin
                    if (append_ok)
                        len_next = len_reg + 1'b1;
                    pmv_next  = '0;
                    pos_next  = '0;
                    term_next = 1'b0;
                    hit_next  = 1'b0;
                end
                OP_TITLE:
                begin
                    if (in_window)
                    begin
                        term_next = term_now;
                        if (len_reg != '0)
                        begin
                            pmv_next = step_vec;
                            hit_next = hit_reg || step_hit;
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    give_result = pop_item.last_byte;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (len_reg == '0)
            result_status = STATUS_EMPTY;
        else if (pop_item.record_deleted)
            result_status = STATUS_DELETED;
        else if (hit_next)
            result_status = STATUS_MATCH;
        else
            result_status = STATUS_NO_MATCH;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        if (give_result)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pmv_reg       <= '0;
            pos_reg       <= '0;
            term_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            // a finished record drops its title state
            if (give_result)
            begin
                pmv_reg  <= '0;
                pos_reg  <= '0;
                term_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                pmv_reg  <= pmv_next;
                pos_reg  <= pos_next;
                term_reg <= term_next;
                hit_reg  <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && pop_item.kind == OP_APPEND && append_ok)
            pattern_reg[len_reg] <= pop_item.folded_byte;
        if (give_result)
        begin
            status_reg <= result_status;
            record_reg <= pop_item.record_number;
        end
    end

    assign result_valid   = out_valid_reg;
    assign status         = status_reg;
    assign matched_record = record_reg;

endmodule
